// ----- rtl/mi3_pkg.sv -----
package mi3_pkg;

	localparam int LANES = 9;
	// lane depth: magnitude stage, entry stage, one stage per quotient bit
	localparam int LANE_DEPTH = 34;
	localparam logic [31:0] THRESH_RESET = 32'd17;
	localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m10;
		logic signed [15:0] m11;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
	} mat_t;

	typedef struct packed {
		logic signed [31:0] inv00;
		logic signed [31:0] inv01;
		logic signed [31:0] inv02;
		logic signed [31:0] inv10;
		logic signed [31:0] inv11;
		logic signed [31:0] inv12;
		logic signed [31:0] inv20;
		logic signed [31:0] inv21;
		logic signed [31:0] inv22;
		logic               singular;
		logic signed [51:0] det_value;
	} inv_t;

	// adjugate entries (transposed cofactors), row-major, index 0 is c00
	typedef logic [LANES-1:0][32:0] cof_arr_t;

	typedef struct packed {
		logic               valid;
		logic signed [51:0] det;
	} front_stat_t;

endpackage

// ----- rtl/matrix_inverse_3x3_top.sv -----
// Throughput: one matrix per cycle; busy is always low and the result cannot be stalled.
// The nine parallel divider lanes each hold 32 restoring stages, one quotient bit a stage.
// Reset: arst_n clears all valid bits and sets the singular threshold to 17.
module matrix_inverse_3x3_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  mi3_pkg::mat_t   req,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [31:0]     cfg_data,
	output logic            done,
	output mi3_pkg::inv_t   res
);
	import mi3_pkg::*;

	cof_arr_t           cof;
	front_stat_t        stat;
	logic signed [31:0] quo [LANES];
	logic [31:0]        thresh_q;
	logic [51:0]        dmag_q;
	logic [51:0]        dneg;
	logic signed [51:0] det_d [1:LANE_DEPTH];
	logic               sing_d [2:LANE_DEPTH];
	logic [LANE_DEPTH:1] vld_d;
	logic               done_q;
	inv_t               res_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	mi3_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.mat      (req),
		.cof      (cof),
		.stat     (stat)
	);

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		mi3_div_lane u_lane (
			.clk (clk),
			.cof ($signed(cof[i])),
			.det (stat.det),
			.quo (quo[i])
		);
	end

	// hold the threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thresh_q <= cfg_data;
		end
	end

	// decide singularity and delay it with the determinant
	assign dneg = 52'd0 - stat.det;

	always_ff @(posedge clk) begin
		dmag_q    <= stat.det[51] ? dneg : stat.det;
		det_d[1]  <= stat.det;
		sing_d[2] <= (dmag_q == '0) || (dmag_q < {20'd0, thresh_q});
		for (int k = 2; k <= LANE_DEPTH; k++) begin
			det_d[k] <= det_d[k-1];
		end
		for (int k = 3; k <= LANE_DEPTH; k++) begin
			sing_d[k] <= sing_d[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_d  <= '0;
			done_q <= 1'b0;
		end else begin
			vld_d  <= {vld_d[LANE_DEPTH-1:1], stat.valid};
			done_q <= vld_d[LANE_DEPTH];
		end
	end

	// merge lane quotients into the result, zero when singular
	always_ff @(posedge clk) begin
		res_q.inv00     <= sing_d[LANE_DEPTH] ? '0 : quo[0];
		res_q.inv01     <= sing_d[LANE_DEPTH] ? '0 : quo[1];
		res_q.inv02     <= sing_d[LANE_DEPTH] ? '0 : quo[2];
		res_q.inv10     <= sing_d[LANE_DEPTH] ? '0 : quo[3];
		res_q.inv11     <= sing_d[LANE_DEPTH] ? '0 : quo[4];
		res_q.inv12     <= sing_d[LANE_DEPTH] ? '0 : quo[5];
		res_q.inv20     <= sing_d[LANE_DEPTH] ? '0 : quo[6];
		res_q.inv21     <= sing_d[LANE_DEPTH] ? '0 : quo[7];
		res_q.inv22     <= sing_d[LANE_DEPTH] ? '0 : quo[8];
		res_q.singular  <= sing_d[LANE_DEPTH];
		res_q.det_value <= det_d[LANE_DEPTH];
	end

	assign done = done_q;
	assign res  = res_q;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##39 done)
		else $error("result strobe missing after request");

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.singular) |-> (res.inv00 == 0 && res.inv11 == 0 && res.inv22 == 0))
		else $error("singular result carries nonzero inverse");

	a_det_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !res.singular) |-> (res.det_value != 0))
		else $error("zero determinant not flagged singular");
`endif

endmodule

// ----- rtl/mi3_front.sv -----
module mi3_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  mi3_pkg::mat_t     mat,
	output mi3_pkg::cof_arr_t cof,
	output mi3_pkg::front_stat_t stat
);
	import mi3_pkg::*;

	logic signed [31:0] pa_s1 [LANES];
	logic signed [31:0] pb_s1 [LANES];
	logic signed [15:0] c0_s1 [3];
	logic signed [15:0] c0_s2 [3];
	cof_arr_t           cof_s2, cof_s3, cof_s4;
	logic signed [48:0] dp_s3 [3];
	logic signed [51:0] det_s4;
	logic [3:0]         vld_q;

	// form the eighteen cofactor products
	always_ff @(posedge clk) begin
		pa_s1[0] <= mat.m11 * mat.m22;  pb_s1[0] <= mat.m12 * mat.m21;
		pa_s1[1] <= mat.m02 * mat.m21;  pb_s1[1] <= mat.m01 * mat.m22;
		pa_s1[2] <= mat.m01 * mat.m12;  pb_s1[2] <= mat.m11 * mat.m02;
		pa_s1[3] <= mat.m12 * mat.m20;  pb_s1[3] <= mat.m10 * mat.m22;
		pa_s1[4] <= mat.m00 * mat.m22;  pb_s1[4] <= mat.m02 * mat.m20;
		pa_s1[5] <= mat.m02 * mat.m10;  pb_s1[5] <= mat.m00 * mat.m12;
		pa_s1[6] <= mat.m10 * mat.m21;  pb_s1[6] <= mat.m11 * mat.m20;
		pa_s1[7] <= mat.m01 * mat.m20;  pb_s1[7] <= mat.m00 * mat.m21;
		pa_s1[8] <= mat.m00 * mat.m11;  pb_s1[8] <= mat.m01 * mat.m10;
		c0_s1[0] <= mat.m00;
		c0_s1[1] <= mat.m10;
		c0_s1[2] <= mat.m20;
	end

	// subtract product pairs into cofactors
	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			cof_s2[i] <= 33'(pa_s1[i]) - 33'(pb_s1[i]);
		end
		c0_s2 <= c0_s1;
	end

	// expand the determinant down the first column
	always_ff @(posedge clk) begin
		dp_s3[0] <= c0_s2[0] * $signed(cof_s2[0]);
		dp_s3[1] <= c0_s2[1] * $signed(cof_s2[1]);
		dp_s3[2] <= c0_s2[2] * $signed(cof_s2[2]);
		cof_s3   <= cof_s2;
	end

	always_ff @(posedge clk) begin
		det_s4 <= 52'(dp_s3[0]) + 52'(dp_s3[1]) + 52'(dp_s3[2]);
		cof_s4 <= cof_s3;
	end

	// advance the request valid alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[2:0], in_valid};
		end
	end

	assign cof        = cof_s4;
	assign stat.valid = vld_q[3];
	assign stat.det   = det_s4;

endmodule

// ----- rtl/mi3_div_lane.sv -----
module mi3_div_lane (
	input  logic               clk,
	input  logic signed [32:0] cof,
	input  logic signed [51:0] det,
	output logic signed [31:0] quo
);
	import mi3_pkg::*;

	logic [31:0] nmag_s1;
	logic [51:0] dmag_s1;
	logic        neg_s1;
	logic [32:0] cneg;
	logic [51:0] dneg;

	logic [51:0] rem_s [0:32];
	logic [51:0] den_s [0:32];
	logic [31:0] nlo_s [0:32];
	logic [31:0] quo_s [0:32];
	logic        neg_s [0:32];
	logic        ovf_s [0:32];

	assign cneg = 33'd0 - cof;
	assign dneg = 52'd0 - det;

	// take magnitudes and the quotient sign
	always_ff @(posedge clk) begin
		nmag_s1 <= cof[32] ? cneg[31:0] : cof[31:0];
		dmag_s1 <= det[51] ? dneg : det;
		neg_s1  <= cof[32] ^ det[51];
	end

	// load the divider; flag quotients that cannot fit 32 bits
	always_ff @(posedge clk) begin
		rem_s[0] <= {28'd0, nmag_s1[31:8]};
		nlo_s[0] <= {nmag_s1[7:0], 24'd0};
		den_s[0] <= dmag_s1;
		quo_s[0] <= '0;
		neg_s[0] <= neg_s1;
		ovf_s[0] <= {28'd0, nmag_s1[31:8]} >= dmag_s1;
	end

	// one restoring step per stage, one quotient bit each
	for (genvar k = 0; k < 32; k++) begin : g_step
		logic [52:0] trial;
		assign trial = {rem_s[k], nlo_s[k][31]};
		always_ff @(posedge clk) begin
			if (trial >= {1'b0, den_s[k]}) begin
				rem_s[k+1] <= 52'(trial - {1'b0, den_s[k]});
				quo_s[k+1] <= {quo_s[k][30:0], 1'b1};
			end else begin
				rem_s[k+1] <= trial[51:0];
				quo_s[k+1] <= {quo_s[k][30:0], 1'b0};
			end
			nlo_s[k+1] <= {nlo_s[k][30:0], 1'b0};
			den_s[k+1] <= den_s[k];
			neg_s[k+1] <= neg_s[k];
			ovf_s[k+1] <= ovf_s[k];
		end
	end

	// apply sign and saturate
	always_comb begin
		if (ovf_s[32]) begin
			quo = neg_s[32] ? Q_MIN : Q_MAX;
		end else if (neg_s[32]) begin
			quo = (quo_s[32] > 32'h8000_0000) ? Q_MIN : $signed(32'd0 - quo_s[32]);
		end else begin
			quo = quo_s[32][31] ? Q_MAX : $signed(quo_s[32]);
		end
	end

endmodule

// ----- tb/matrix_inverse_3x3_top_tb.sv -----
`timescale 1ns / 100ps

module matrix_inverse_3x3_top_tb;
	import mi3_pkg::*;

	localparam int DRAIN_CYCLES = 45;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 800;

	// expected inverses, oldest first, plus the checker
	class inverse_board;
		inv_t pending[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
			errors++;
		endtask

		// compute the adjugate inverse the block should return
		function inv_t predict(mat_t m, logic [31:0] thr);
			longint a[3][3];
			longint cof[9];
			longint det, mag, q;
			logic sing;
			logic [31:0] qv[9];
			inv_t r;
			a[0][0] = m.m00; a[0][1] = m.m01; a[0][2] = m.m02;
			a[1][0] = m.m10; a[1][1] = m.m11; a[1][2] = m.m12;
			a[2][0] = m.m20; a[2][1] = m.m21; a[2][2] = m.m22;
			det = a[0][0] * a[1][1] * a[2][2] - a[0][0] * a[2][1] * a[1][2]
				+ a[1][0] * a[2][1] * a[0][2] - a[1][0] * a[0][1] * a[2][2]
				+ a[2][0] * a[0][1] * a[1][2] - a[2][0] * a[1][1] * a[0][2];
			cof[0] = a[1][1] * a[2][2] - a[1][2] * a[2][1];
			cof[1] = a[0][2] * a[2][1] - a[0][1] * a[2][2];
			cof[2] = a[0][1] * a[1][2] - a[1][1] * a[0][2];
			cof[3] = a[1][2] * a[2][0] - a[1][0] * a[2][2];
			cof[4] = a[0][0] * a[2][2] - a[0][2] * a[2][0];
			cof[5] = a[0][2] * a[1][0] - a[0][0] * a[1][2];
			cof[6] = a[1][0] * a[2][1] - a[1][1] * a[2][0];
			cof[7] = a[0][1] * a[2][0] - a[0][0] * a[2][1];
			cof[8] = a[0][0] * a[1][1] - a[0][1] * a[1][0];
			mag = (det < 0) ? -det : det;
			sing = (det == 0) || (mag < longint'({32'b0, thr}));
			for (int i = 0; i < 9; i++) begin
				q = 0;
				if (!sing) begin
					q = (cof[i] * 64'sd16777216) / det;
					if (q > 64'sd2147483647)
						q = 64'sd2147483647;
					else if (q < -64'sd2147483648)
						q = -64'sd2147483648;
				end
				qv[i] = q[31:0];
			end
			r.inv00 = qv[0]; r.inv01 = qv[1]; r.inv02 = qv[2];
			r.inv10 = qv[3]; r.inv11 = qv[4]; r.inv12 = qv[5];
			r.inv20 = qv[6]; r.inv21 = qv[7]; r.inv22 = qv[8];
			r.singular = sing;
			r.det_value = det[51:0];
			return r;
		endfunction

		function void note_request(mat_t m, logic [31:0] thr);
			pending.push_back(predict(m, thr));
		endfunction

		task check_result(inv_t got);
			inv_t want;
			if (pending.size() == 0) begin
				$display("unexpected result at %0t", $time);
				errors++;
			end else begin
				want = pending.pop_front();
				if (got.inv00 !== want.inv00) report("inv00", got.inv00, want.inv00);
				if (got.inv01 !== want.inv01) report("inv01", got.inv01, want.inv01);
				if (got.inv02 !== want.inv02) report("inv02", got.inv02, want.inv02);
				if (got.inv10 !== want.inv10) report("inv10", got.inv10, want.inv10);
				if (got.inv11 !== want.inv11) report("inv11", got.inv11, want.inv11);
				if (got.inv12 !== want.inv12) report("inv12", got.inv12, want.inv12);
				if (got.inv20 !== want.inv20) report("inv20", got.inv20, want.inv20);
				if (got.inv21 !== want.inv21) report("inv21", got.inv21, want.inv21);
				if (got.inv22 !== want.inv22) report("inv22", got.inv22, want.inv22);
				if (got.singular !== want.singular)
					report("singular", got.singular, want.singular);
				if (got.det_value !== want.det_value)
					report("det_value", got.det_value, want.det_value);
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	mat_t req = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [31:0] cfg_data = '0;
	logic done;
	inv_t res;

	logic [31:0] threshold = THRESH_RESET;
	int burst_left = 0;
	int cycles = 0;
	inverse_board board = new();

	matrix_inverse_3x3_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .res(res)
	);

	always #10 clk = ~clk;

	// note accepted requests and check results
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				board.note_request(req, threshold);
			if (done)
				board.check_result(res);
		end
	end

	// stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// send one request, with bursts and random gaps between them
	task send_matrix(mat_t m);
		if (burst_left == 0) begin
			start = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		start = 1'b1;
		req = m;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		burst_left--;
	endtask

	// hold until every result is back and the pipe is empty
	task drain;
		start = 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task write_threshold(logic [31:0] v);
		drain();
		cfg_valid = 1'b1;
		cfg_data = v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		threshold = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic mat_t diag(logic [15:0] d0, logic [15:0] d1, logic [15:0] d2);
		mat_t m;
		m = '0;
		m.m00 = d0; m.m11 = d1; m.m22 = d2;
		return m;
	endfunction

	function automatic mat_t rand_matrix(int kind);
		mat_t m;
		int sp;
		m = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
		case (kind)
			0: ;
			// small entries give small determinants near the threshold
			1: begin
				sp = $urandom_range(1, 8);
				m.m00 = 16'($signed($urandom_range(0, 2 * sp)) - sp);
				m.m01 = 16'($signed($urandom_range(0, 2 * sp)) - sp);
				m.m02 = 16'($signed($urandom_range(0, 2 * sp)) - sp);
				m.m10 = 16'($signed($urandom_range(0, 2 * sp)) - sp);
				m.m11 = 16'($signed($urandom_range(0, 2 * sp)) - sp);
				m.m12 = 16'($signed($urandom_range(0, 2 * sp)) - sp);
				m.m20 = 16'($signed($urandom_range(0, 2 * sp)) - sp);
				m.m21 = 16'($signed($urandom_range(0, 2 * sp)) - sp);
				m.m22 = 16'($signed($urandom_range(0, 2 * sp)) - sp);
			end
			// repeated row: exactly singular
			2: begin
				m.m20 = m.m00; m.m21 = m.m01; m.m22 = m.m02;
			end
			// moderate Q8.8 values around unity
			default: begin
				m.m00 = 16'($signed($urandom_range(0, 1024)) - 512);
				m.m01 = 16'($signed($urandom_range(0, 1024)) - 512);
				m.m02 = 16'($signed($urandom_range(0, 1024)) - 512);
				m.m10 = 16'($signed($urandom_range(0, 1024)) - 512);
				m.m11 = 16'($signed($urandom_range(0, 1024)) - 512);
				m.m12 = 16'($signed($urandom_range(0, 1024)) - 512);
				m.m20 = 16'($signed($urandom_range(0, 1024)) - 512);
				m.m21 = 16'($signed($urandom_range(0, 1024)) - 512);
				m.m22 = 16'($signed($urandom_range(0, 1024)) - 512);
			end
		endcase
		return m;
	endfunction

	task random_phase(int n);
		for (int i = 0; i < n; i++)
			send_matrix(rand_matrix($urandom_range(0, 4)));
	endtask

	initial begin
		mat_t m;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: identity, zero, extremes, tiny determinant, saturation
		send_matrix(diag(16'sd256, 16'sd256, 16'sd256));
		send_matrix('0);
		send_matrix(diag(16'sd1, 16'sd1, 16'sd1));
		send_matrix(diag(16'sd2, 16'sd3, 16'sd3));
		send_matrix(diag(-16'sd32768, -16'sd32768, -16'sd32768));
		send_matrix(diag(16'sd32767, 16'sd32767, 16'sd32767));
		send_matrix(diag(16'sd32767, -16'sd32768, 16'sd32767));
		m = {9{16'h8000}};
		send_matrix(m);
		m = {9{16'h7fff}};
		send_matrix(m);
		m = '0;
		m.m00 = 16'sd32767; m.m01 = 16'sd32766; m.m10 = 16'sd1; m.m11 = 16'sd1;
		m.m22 = 16'sd1;
		send_matrix(m);
		m.m22 = -16'sd1;
		send_matrix(m);
		m = {16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
			16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
		send_matrix(m);
		m = {16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd256, 16'sd0};
		send_matrix(m);

		// zero threshold: only an exact zero determinant is singular
		write_threshold(32'd0);
		send_matrix('0);
		send_matrix(diag(16'sd1, 16'sd1, 16'sd1));
		send_matrix(m);
		random_phase(RANDOM_ITEMS / 4);

		// all-ones threshold
		write_threshold(32'hffff_ffff);
		send_matrix(diag(16'sd256, 16'sd256, 16'sd256));
		send_matrix(diag(16'sd4096, 16'sd4096, 16'sd4096));
		random_phase(RANDOM_ITEMS / 8);

		// a threshold near unit determinant
		write_threshold(32'd16777216);
		send_matrix(diag(16'sd256, 16'sd256, 16'sd256));
		send_matrix(diag(16'sd256, 16'sd256, 16'sd255));
		random_phase(RANDOM_ITEMS / 8);

		write_threshold($urandom);
		random_phase(RANDOM_ITEMS / 4);

		write_threshold(THRESH_RESET);
		random_phase(RANDOM_ITEMS / 4);

		drain();
		if (board.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- matrix_inverse_3x3_top.f -----
rtl/mi3_pkg.sv
rtl/mi3_front.sv
rtl/mi3_div_lane.sv
rtl/matrix_inverse_3x3_top.sv
tb/matrix_inverse_3x3_top_tb.sv
